### rtl/btx_pkg.sv
package btx_pkg;

   // default texture limits
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   // size of the register reset value for both dimensions
   localparam int RESET_DIM = 256;

   // item commands
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // configuration register indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // fixed-point formats
   localparam int COORD_W  = 17;
   localparam int FRAC_W   = 16;
   localparam int CHAN_W   = 8;
   localparam int TEXEL_W  = 3 * CHAN_W;
   localparam int WEIGHT_W = 33;
   localparam int PROD_W   = WEIGHT_W + CHAN_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int OUT_W    = 16;
   localparam int RND_SH   = 24;
   localparam logic [COORD_W-1:0] COORD_ONE = 17'h10000;

   // number of footprint corners: 00, 01 (y+1), 10 (x+1), 11
   localparam int CORNERS = 4;

endpackage

### rtl/btx_store.sv
// Texel store: four identical copies, one per footprint corner, so that all
// four corners are read together. Every write goes to all copies.
module btx_store #(
   parameter int DEPTH = btx_pkg::DEF_MAX_WIDTH * btx_pkg::DEF_MAX_HEIGHT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                                            clock,
   input  logic                                            wr_en,
   input  logic [AW-1:0]                                   wr_addr,
   input  logic [btx_pkg::TEXEL_W-1:0]                     wr_data,
   input  logic                                            rd_en,
   input  logic [btx_pkg::CORNERS-1:0][AW-1:0]             rd_addr,
   output logic [btx_pkg::CORNERS-1:0][btx_pkg::TEXEL_W-1:0] rd_data
);

   for (genvar g = 0; g < btx_pkg::CORNERS; g++) begin : g_copy
      logic [btx_pkg::TEXEL_W-1:0] mem [DEPTH];
      logic [btx_pkg::TEXEL_W-1:0] rd_ff;

      // one write port, one registered read port
      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            rd_ff <= mem[rd_addr[g]];
         end
      end

      assign rd_data[g] = rd_ff;
   end

endmodule

### rtl/bilinear_texture_sampler.sv
// Bilinear texture sampler. Texel writes (command 0) and samples (command 1)
// share one valid/ready channel and keep their order: a sample sees every
// write accepted before it. One item is accepted per clock when the result
// side keeps up; a sample's result leaves through the output register, and
// writes produce no result. The rate is set by the texel store, which keeps
// four copies of the texture so the 2x2 footprint is read all together.
// The store comes up undefined and has no clearing pass: sample only texels
// that were written. Width and height registers are clamped to 1..MAX and
// may be changed only while the block is idle.
module bilinear_texture_sampler #(
   parameter int MAX_WIDTH  = btx_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = btx_pkg::DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [15:0] req_texel_index,
   input  logic [7:0]  req_texel_red,
   input  logic [7:0]  req_texel_green,
   input  logic [7:0]  req_texel_blue,
   input  logic [16:0] req_coord_u,
   input  logic [16:0] req_coord_v,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_sample_red,
   output logic [15:0] rsp_sample_green,
   output logic [15:0] rsp_sample_blue,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int CW    = btx_pkg::COORD_W;
   localparam int FW    = btx_pkg::FRAC_W;
   localparam int UW    = CW + WW;
   localparam int VW    = CW + HW;
   localparam int MW    = YW + WW;
   localparam int TW    = btx_pkg::TEXEL_W;
   localparam int NC    = btx_pkg::CORNERS;
   localparam int RST_W = (btx_pkg::RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : btx_pkg::RESET_DIM;
   localparam int RST_H = (btx_pkg::RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : btx_pkg::RESET_DIM;

   logic advance;

   // configuration, clamped on write
   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we && csr_index == btx_pkg::REG_WIDTH) begin
         if (csr_wdata == 9'd0) begin
            width_in = WW'(1);
         end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
            width_in = WW'(MAX_WIDTH);
         end else begin
            width_in = WW'(csr_wdata);
         end
      end
      if (csr_we && csr_index == btx_pkg::REG_HEIGHT) begin
         if (csr_wdata == 9'd0) begin
            height_in = HW'(1);
         end else if (32'(csr_wdata) > 32'(MAX_HEIGHT)) begin
            height_in = HW'(MAX_HEIGHT);
         end else begin
            height_in = HW'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(RST_W);
         height_ff <= HW'(RST_H);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // whole pipeline moves when the output register is free or drains
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // ---------------- stage 1: capture, saturate coordinates
   logic          s1_valid_ff;
   logic          s1_cmd_ff, s1_wok_ff;
   logic [15:0]   s1_idx_ff;
   logic [TW-1:0] s1_rgb_ff;
   logic [CW-1:0] s1_u_ff, s1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
      if (advance) begin
         s1_cmd_ff <= req_command;
         s1_idx_ff <= req_texel_index;
         s1_wok_ff <= 32'(req_texel_index) < 32'(DEPTH);
         s1_rgb_ff <= {req_texel_red, req_texel_green, req_texel_blue};
         s1_u_ff   <= (req_coord_u > btx_pkg::COORD_ONE) ? btx_pkg::COORD_ONE : req_coord_u;
         s1_v_ff   <= (req_coord_v > btx_pkg::COORD_ONE) ? btx_pkg::COORD_ONE : req_coord_v;
      end
   end

   // ---------------- stage 2: scale by (size - 1)
   logic          s2_valid_ff;
   logic          s2_cmd_ff, s2_wok_ff;
   logic [15:0]   s2_idx_ff;
   logic [TW-1:0] s2_rgb_ff;
   logic [UW-1:0] s2_su_ff;
   logic [VW-1:0] s2_sv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_cmd_ff <= s1_cmd_ff;
         s2_idx_ff <= s1_idx_ff;
         s2_wok_ff <= s1_wok_ff;
         s2_rgb_ff <= s1_rgb_ff;
         s2_su_ff  <= UW'(s1_u_ff) * UW'(width_ff - WW'(1));
         s2_sv_ff  <= VW'(s1_v_ff) * VW'(height_ff - HW'(1));
      end
   end

   // ---------------- stage 3: row offset and corner weights
   logic [FW-1:0] fu, fv;
   logic [CW-1:0] wu0, wv0;
   logic [XW-1:0] x0;
   logic [YW-1:0] y0;

   assign fu  = s2_su_ff[FW-1:0];
   assign fv  = s2_sv_ff[FW-1:0];
   assign x0  = s2_su_ff[FW +: XW];
   assign y0  = s2_sv_ff[FW +: YW];
   assign wu0 = btx_pkg::COORD_ONE - CW'(fu);
   assign wv0 = btx_pkg::COORD_ONE - CW'(fv);

   logic          s3_valid_ff;
   logic          s3_cmd_ff, s3_wok_ff, s3_nzu_ff, s3_nzv_ff;
   logic [15:0]   s3_idx_ff;
   logic [TW-1:0] s3_rgb_ff;
   logic [XW-1:0] s3_x0_ff;
   logic [MW-1:0] s3_ymul_ff;
   logic [NC-1:0][btx_pkg::WEIGHT_W-1:0] s3_wt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_cmd_ff   <= s2_cmd_ff;
         s3_idx_ff   <= s2_idx_ff;
         s3_wok_ff   <= s2_wok_ff;
         s3_rgb_ff   <= s2_rgb_ff;
         s3_nzu_ff   <= fu != '0;
         s3_nzv_ff   <= fv != '0;
         s3_x0_ff    <= x0;
         s3_ymul_ff  <= MW'(y0) * MW'(width_ff);
         s3_wt_ff[0] <= btx_pkg::WEIGHT_W'(34'(wu0) * 34'(wv0));
         s3_wt_ff[1] <= btx_pkg::WEIGHT_W'(34'(wu0) * 34'(fv));
         s3_wt_ff[2] <= btx_pkg::WEIGHT_W'(34'(fu) * 34'(wv0));
         s3_wt_ff[3] <= btx_pkg::WEIGHT_W'(34'(fu) * 34'(fv));
      end
   end

   // ---------------- stage 4: corner addresses
   logic [AW-1:0] base;
   assign base = AW'(s3_ymul_ff) + AW'(s3_x0_ff);

   logic          s4_valid_ff;
   logic          s4_cmd_ff, s4_wok_ff, s4_nzu_ff, s4_nzv_ff;
   logic [AW-1:0] s4_waddr_ff;
   logic [TW-1:0] s4_rgb_ff;
   logic [NC-1:0][AW-1:0] s4_addr_ff;
   logic [NC-1:0][btx_pkg::WEIGHT_W-1:0] s4_wt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_cmd_ff     <= s3_cmd_ff;
         s4_wok_ff     <= s3_wok_ff;
         s4_nzu_ff     <= s3_nzu_ff;
         s4_nzv_ff     <= s3_nzv_ff;
         s4_waddr_ff   <= AW'(s3_idx_ff);
         s4_rgb_ff     <= s3_rgb_ff;
         s4_wt_ff      <= s3_wt_ff;
         s4_addr_ff[0] <= base;
         s4_addr_ff[1] <= base + AW'(width_ff);
         s4_addr_ff[2] <= base + AW'(1);
         s4_addr_ff[3] <= base + AW'(width_ff) + AW'(1);
      end
   end

   // ---------------- stage 5: store access (writes end here)
   logic                  st_wr_en, st_rd_en;
   logic [NC-1:0][TW-1:0] st_rd_data;

   assign st_wr_en = advance && s4_valid_ff && s4_cmd_ff == btx_pkg::CMD_WRITE && s4_wok_ff;
   assign st_rd_en = advance && s4_valid_ff && s4_cmd_ff == btx_pkg::CMD_SAMPLE;

   btx_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (s4_waddr_ff),
      .wr_data (s4_rgb_ff),
      .rd_en   (st_rd_en),
      .rd_addr (s4_addr_ff),
      .rd_data (st_rd_data)
   );

   logic                  s5_valid_ff;
   logic [NC-1:0]         s5_use_ff;
   logic [NC-1:0][btx_pkg::WEIGHT_W-1:0] s5_wt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff && s4_cmd_ff == btx_pkg::CMD_SAMPLE;
      end
      if (advance) begin
         s5_wt_ff  <= s4_wt_ff;
         s5_use_ff <= {s4_nzu_ff && s4_nzv_ff, s4_nzu_ff, s4_nzv_ff, 1'b1};
      end
   end

   // ---------------- stage 6: channel times weight; unused corners read as zero
   logic [NC-1:0][TW-1:0] texel;
   always_comb begin
      for (int k = 0; k < NC; k++) begin
         texel[k] = s5_use_ff[k] ? st_rd_data[k] : '0;
      end
   end

   logic s6_valid_ff;
   logic [NC-1:0][2:0][btx_pkg::PROD_W-1:0] s6_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
      end
      if (advance) begin
         for (int k = 0; k < NC; k++) begin
            for (int c = 0; c < 3; c++) begin
               s6_prod_ff[k][c] <= btx_pkg::PROD_W'(texel[k][c*btx_pkg::CHAN_W +: btx_pkg::CHAN_W])
                                   * btx_pkg::PROD_W'(s5_wt_ff[k]);
            end
         end
      end
   end

   // ---------------- stage 7: sum, round to 8.8, output register
   logic [2:0][btx_pkg::SUM_W-1:0] sum;
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c] = btx_pkg::SUM_W'(s6_prod_ff[0][c]) + btx_pkg::SUM_W'(s6_prod_ff[1][c])
                + btx_pkg::SUM_W'(s6_prod_ff[2][c]) + btx_pkg::SUM_W'(s6_prod_ff[3][c])
                + (btx_pkg::SUM_W'(1) << (btx_pkg::RND_SH - 1));
      end
   end

   logic                              rsp_valid_ff;
   logic [2:0][btx_pkg::OUT_W-1:0]    rsp_chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s6_valid_ff;
      end
      if (advance) begin
         for (int c = 0; c < 3; c++) begin
            rsp_chan_ff[c] <= sum[c][btx_pkg::RND_SH +: btx_pkg::OUT_W];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_red   = rsp_chan_ff[2];
   assign rsp_sample_green = rsp_chan_ff[1];
   assign rsp_sample_blue  = rsp_chan_ff[0];

endmodule

### tb/bilinear_texture_checker.sv
`timescale 1ns / 1ps

module bilinear_texture_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_command,
   input  logic [15:0] req_texel_index,
   input  logic [7:0]  req_texel_red,
   input  logic [7:0]  req_texel_green,
   input  logic [7:0]  req_texel_blue,
   input  logic [16:0] req_coord_u,
   input  logic [16:0] req_coord_v,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_sample_red,
   input  logic [15:0] rsp_sample_green,
   input  logic [15:0] rsp_sample_blue,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata,
   output int          mismatches,
   output int          pending
);
   import btx_pkg::*;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } rgb_sample_t;

   bit [23:0]   texels [0:65535];
   logic [8:0]  width_reg = 9'd256;
   logic [8:0]  height_reg = 9'd256;
   rgb_sample_t samples_due [$];

   initial mismatches = 0;
   assign pending = samples_due.size();

   function automatic int unsigned clamp_dim(logic [8:0] value, int unsigned limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   // bilinear blend of the 2x2 footprint, zero-weight corners skipped
   function automatic rgb_sample_t bilinear_blend(logic [16:0] cu, logic [16:0] cv);
      int unsigned     w, h, u, v, su, sv, x0, y0, fu, fv, addr;
      longint unsigned wgt;
      longint unsigned acc [3];
      bit [23:0]       t;
      bit              dx, dy;
      rgb_sample_t     r;
      w = clamp_dim(width_reg, DEF_MAX_WIDTH);
      h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
      u = (cu > COORD_ONE) ? 65536 : cu;
      v = (cv > COORD_ONE) ? 65536 : cv;
      su = u * (w - 1);
      sv = v * (h - 1);
      x0 = su >> 16;
      y0 = sv >> 16;
      fu = su & 16'hFFFF;
      fv = sv & 16'hFFFF;
      acc[0] = 0; acc[1] = 0; acc[2] = 0;
      for (int k = 0; k < CORNERS; k++) begin
         dx = k[1];
         dy = k[0];
         if ((dx && fu == 0) || (dy && fv == 0)) continue;
         wgt = longint'(dx ? fu : 65536 - fu) * longint'(dy ? fv : 65536 - fv);
         addr = (x0 + dx) + (y0 + dy) * w;
         t = texels[addr[15:0]];
         acc[0] += longint'(t[23:16]) * wgt;
         acc[1] += longint'(t[15:8]) * wgt;
         acc[2] += longint'(t[7:0]) * wgt;
      end
      r.red   = 16'((acc[0] + (64'd1 << 23)) >> RND_SH);
      r.green = 16'((acc[1] + (64'd1 << 23)) >> RND_SH);
      r.blue  = 16'((acc[2] + (64'd1 << 23)) >> RND_SH);
      return r;
   endfunction

   always @(posedge clock) begin
      rgb_sample_t want;
      if (reset) begin
         width_reg  <= 9'd256;
         height_reg <= 9'd256;
      end else begin
         // result transfer: compare against oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (samples_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result r=%h g=%h b=%h", $realtime,
                           rsp_sample_red, rsp_sample_green, rsp_sample_blue);
            end else begin
               want = samples_due.pop_front();
               if (want.red !== rsp_sample_red || want.green !== rsp_sample_green ||
                   want.blue !== rsp_sample_blue) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: sample exp r=%h g=%h b=%h got r=%h g=%h b=%h",
                              $realtime, want.red, want.green, want.blue,
                              rsp_sample_red, rsp_sample_green, rsp_sample_blue);
               end
            end
         end
         // request transfer: update store or queue a prediction
         if (req_valid && req_ready) begin
            if (req_command == CMD_WRITE)
               texels[req_texel_index] = {req_texel_red, req_texel_green, req_texel_blue};
            else
               samples_due.push_back(bilinear_blend(req_coord_u, req_coord_v));
         end
         if (csr_we) begin
            if (csr_index == REG_WIDTH) width_reg <= csr_wdata;
            else                        height_reg <= csr_wdata;
         end
      end
   end

endmodule

### tb/bilinear_texture_sampler_test.sv
`timescale 1ns / 1ps

module bilinear_texture_sampler_test;
   import btx_pkg::*;

   localparam int RANDOM_ITEMS = 1750;
   localparam int STALL_LIMIT  = 20000;
   localparam int SETTINGS_N   = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = CMD_WRITE;
   logic [15:0] req_texel_index = '0;
   logic [7:0]  req_texel_red = '0;
   logic [7:0]  req_texel_green = '0;
   logic [7:0]  req_texel_blue = '0;
   logic [16:0] req_coord_u = '0;
   logic [16:0] req_coord_v = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_sample_red, rsp_sample_green, rsp_sample_blue;
   logic        csr_we = 1'b0;
   logic        csr_index = REG_WIDTH;
   logic [8:0]  csr_wdata = '0;
   int          mismatches, pending;

   // stimulus bookkeeping
   bit          written [0:65535];
   int unsigned tex_w = 256, tex_h = 256;
   int          idle_mode = 0;
   int          n_writes = 0, n_samples = 0, stall_count = 0;

   // setting list: reset values, minimum, zero and oversize (clamped), small shapes
   int unsigned width_list  [SETTINGS_N] = '{256, 1, 0, 511, 2, 3, 17, 256, 200, 130};
   int unsigned height_list [SETTINGS_N] = '{256, 1, 0, 300, 2, 5, 9, 1, 256, 73};

   always #5 clock = ~clock;

   bilinear_texture_sampler u_dut (.*);

   bilinear_texture_checker u_checker (.*);

   // receiver stalls: heavy first, light next, none last
   always @(posedge clock) begin
      case (idle_mode)
         0: rsp_ready <= ($urandom_range(99) >= 76);
         1: rsp_ready <= ($urandom_range(99) >= 8);
         default: rsp_ready <= 1'b1;
      endcase
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int unsigned clamp_dim(int unsigned value, int unsigned limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   task automatic put_item(logic cmd, logic [15:0] index, logic [23:0] rgb,
                           logic [16:0] cu, logic [16:0] cv);
      int gap_pct;
      gap_pct = (idle_mode == 0) ? 8 : (idle_mode == 1) ? 76 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_texel_index <= index;
      {req_texel_red, req_texel_green, req_texel_blue} <= rgb;
      req_coord_u     <= cu;
      req_coord_v     <= cv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cmd == CMD_WRITE) begin
         written[index] = 1'b1;
         n_writes++;
      end else n_samples++;
   endtask

   task automatic write_texel(logic [15:0] index, logic [23:0] rgb);
      put_item(CMD_WRITE, index, rgb, 17'($urandom), 17'($urandom));
   endtask

   // loads any unwritten texel of the footprint, then sends the sample
   task automatic sample_at(logic [16:0] cu, logic [16:0] cv);
      int unsigned u, v, su, sv, x0, y0, fu, fv, addr;
      u = (cu > COORD_ONE) ? 65536 : cu;
      v = (cv > COORD_ONE) ? 65536 : cv;
      su = u * (tex_w - 1);
      sv = v * (tex_h - 1);
      x0 = su >> 16;
      y0 = sv >> 16;
      fu = su & 16'hFFFF;
      fv = sv & 16'hFFFF;
      for (int k = 0; k < CORNERS; k++) begin
         if ((k[1] && fu == 0) || (k[0] && fv == 0)) continue;
         addr = (x0 + k[1]) + (y0 + k[0]) * tex_w;
         if (!written[addr[15:0]]) write_texel(addr[15:0], 24'($urandom));
      end
      put_item(CMD_SAMPLE, 16'($urandom), 24'($urandom), cu, cv);
   endtask

   task automatic drain_and_wait;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_texture(int unsigned w, int unsigned h);
      csr_we    <= 1'b1;
      csr_index <= REG_WIDTH;
      csr_wdata <= 9'(w);
      @(posedge clock);
      csr_index <= REG_HEIGHT;
      csr_wdata <= 9'(h);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      tex_w = clamp_dim(w, DEF_MAX_WIDTH);
      tex_h = clamp_dim(h, DEF_MAX_HEIGHT);
   endtask

   function automatic logic [16:0] pick_coord();
      case ($urandom_range(9))
         0: return 17'd0;
         1: return COORD_ONE;
         2: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      int start;
      start = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: color extremes, corner texels, coordinate saturation
      write_texel(16'd0, 24'h000000);
      write_texel(16'd1, 24'hFFFFFF);
      write_texel(16'd256, 24'hFF0080);
      write_texel(16'd257, 24'h00FF7F);
      write_texel(16'd255, 24'h01FEFF);
      write_texel(16'd65535, 24'h5AA5FF);
      sample_at(17'd0, 17'd0);
      sample_at(17'h00100, 17'h00100);
      sample_at(17'h00080, 17'h00080);
      sample_at(COORD_ONE, COORD_ONE);
      sample_at(17'h1FFFF, 17'h1FFFF);
      sample_at(17'd1, 17'd65535);
      sample_at(17'd65535, 17'd1);
      sample_at(COORD_ONE, 17'd0);
      sample_at(17'd0, 17'h1FFFF);
      // hold off until the pipeline is empty
      drain_and_wait();

      // random phases across texture settings, paced by items actually sent
      start = n_writes + n_samples;
      for (int s = 0; s < SETTINGS_N; s++) begin
         set_texture(width_list[s], height_list[s]);
         while (n_writes + n_samples - start < (s + 1) * RANDOM_ITEMS / SETTINGS_N) begin
            idle_mode = ((n_writes + n_samples - start) * 3) / RANDOM_ITEMS;
            if ($urandom_range(99) < 20)
               write_texel(16'($urandom), 24'($urandom));
            else
               sample_at(pick_coord(), pick_coord());
         end
         drain_and_wait();
      end

      $display("Covered %0d texel writes and %0d samples over %0d texture settings,",
               n_writes, n_samples, SETTINGS_N);
      $display("including unit size, clamped register values and saturated coordinates.");
      if (mismatches == 0 && pending == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
